// ===== rtl/core/mecanum_odometry_integrator_top_defines.svh =====
// assertion macros for the mecanum odometry integrator
// used by the top level only, no other dependencies
`ifndef MECANUM_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define MECANUM_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

// antecedent in this cycle implies consequent in the same cycle
`define MOI_ASSERT_SAME(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");

// antecedent in this cycle implies consequent in the next cycle
`define MOI_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/mecodo_pkg.sv =====
// shared types and constants of the mecanum odometry integrator
// no dependencies
`default_nettype none

package mecodo_pkg;

	typedef struct packed {
		logic signed [15:0] wheel_one_speed;
		logic signed [15:0] wheel_two_speed;
		logic signed [15:0] wheel_three_speed;
		logic signed [15:0] wheel_four_speed;
		logic [15:0]        elapsed_time;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] velocity_x;
		logic signed [15:0] velocity_y;
		logic signed [15:0] yaw_rate;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic [15:0]        heading;
	} out_item_t;

	// register indexes
	localparam logic [7:0] REG_WHEEL_RADIUS     = 8'd0;
	localparam logic [7:0] REG_INVERSE_AXLE_SUM = 8'd1;
	localparam logic [15:0] WHEEL_RADIUS_RST     = 16'd3277;
	localparam logic [15:0] INVERSE_AXLE_SUM_RST = 16'd609;

	// arithmetic widths
	localparam int CS_W  = 34;
	localparam int MA_W  = 44;
	localparam int MB_W  = 24;
	localparam int PR_W  = MA_W + MB_W;
	localparam int ACC_W = 56;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [MB_W-1:0] INV_TWO_PI  = 24'sd2670177;

	// cordic handshake between top and rotator
	typedef struct packed {
		logic start;
		logic done;
	} cor_ctl_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933405;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335086;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41721;
			5'd15: v = 32'd20860;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2607;
			5'd19: v = 32'd1303;
			5'd20: v = 32'd651;
			5'd21: v = 32'd325;
			5'd22: v = 32'd162;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	// saturate a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [PR_W-1:0] v);
		logic signed [15:0] r;
		if (v > 68'sd32767) r = 16'sh7fff;
		else if (v < -68'sd32768) r = 16'sh8000;
		else r = 16'(v);
		return r;
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) r = 32'sh7fffffff;
		else if (v < -56'sd2147483648) r = 32'sh80000000;
		else r = 32'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mecodo_cordic.sv =====
// iterative cordic rotator: cos and sin of a binary angle in Q4.30
// depends on mecodo_pkg
`default_nettype none

module mecodo_cordic import mecodo_pkg::*; #(
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [ANGLE_BITS-1:0]  angle,
	output logic                        done,
	output logic signed [CS_W-1:0]      cos_val,
	output logic signed [CS_W-1:0]      sin_val
);

	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        quad_q;
	logic signed [CS_W-1:0] x_q, y_q, z_q;
	logic done_q;
	logic signed [CS_W-1:0] c_q, s_q;

	logic [31:0] a32, res;
	logic [1:0]  quad;
	logic signed [CS_W-1:0] dx, dy, at;

	// quarter-turn reduction of the start angle, shift and arctangent terms of the step
	always_comb begin
		a32  = {angle, {(32-ANGLE_BITS){1'b0}}};
		quad = 2'((a32 + 32'h2000_0000) >> 30);
		res  = a32 - {quad, 30'd0};
		dx   = y_q >>> step_q;
		dy   = x_q >>> step_q;
		at   = CS_W'({2'b00, atan_turn(5'(step_q))});
	end

	// rotation steps and quadrant fix-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
				quad_q <= quad;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= CS_W'($signed(res));
			end else if (busy_q) begin
				if (step_q == STEP_W'(CORDIC_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					case (quad_q)
						2'd1: begin c_q <= -y_q; s_q <= x_q; end
						2'd2: begin c_q <= -x_q; s_q <= -y_q; end
						2'd3: begin c_q <= y_q; s_q <= -x_q; end
						default: begin c_q <= x_q; s_q <= y_q; end
					endcase
				end else begin
					step_q <= step_q + 1'b1;
					if (!z_q[CS_W-1]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - at;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + at;
					end
				end
			end
		end
	end

	assign done    = done_q;
	assign cos_val = c_q;
	assign sin_val = s_q;

endmodule

`default_nettype wire

// ===== rtl/core/mecanum_odometry_integrator_top.sv =====
// mecanum odometry integrator, top level with sequencer and shared multiplier
// depends on mecodo_pkg, mecodo_cordic and the assertion macro header
//
// channel  | direction | handshake           | payload
// in       | input     | in_valid / in_stall | in_item_t wheel speeds, elapsed time
// out      | output    | out_valid/out_stall | out_item_t velocities and pose
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a request runs through the cordic steps and twelve passes through one multiplier
// before the result is offered
// in_stall stays high from the accepting edge until the result is loaded
// a stalled result holds the block until out_stall drops
// reset clears the pose and all handshake state and loads the registers' defaults
`default_nettype none
`include "mecanum_odometry_integrator_top_defines.svh"

module mecanum_odometry_integrator_top import mecodo_pkg::*; #(
	parameter int POSITION_BITS = 32,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STEPS  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic signed [ACC_W-1:0] POS_HI = (56'sd1 <<< (POSITION_BITS - 1)) - 56'sd1;
	localparam logic signed [ACC_W-1:0] POS_LO = -POS_HI - 56'sd1;

	typedef enum logic [3:0] {
		S_IDLE, S_CORDIC, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
		S_M8, S_M9, S_M10, S_M11, S_M12, S_M13, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] radius_q, inv_axle_q;
	logic signed [POSITION_BITS-1:0] pose_x_q, pose_y_q;
	logic [ANGLE_BITS-1:0] pose_heading_q;
	logic signed [17:0] sum_q, lat_q, yaw_q;
	logic [15:0] dt_q;
	logic signed [CS_W-1:0] c_q, s_q;
	logic signed [PR_W-1:0] prod_q, acc_q;
	logic signed [21:0] rx_q, ry_q;
	logic signed [39:0] vx_q, vy_q;
	logic signed [51:0] om_q;
	logic out_valid_q;
	out_item_t out_q;

	cor_ctl_t cor;
	logic signed [CS_W-1:0] cor_c, cor_s;
	logic in_acc;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PR_W-1:0] diff, ssum, inc;
	logic signed [ACC_W-1:0] px_next, py_next;
	logic [ANGLE_BITS-1:0] dh;
	logic signed [17:0] w1, w2, w3, w4;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign cor.start = in_acc;
	assign w1 = 18'(in_data.wheel_one_speed);
	assign w2 = 18'(in_data.wheel_two_speed);
	assign w3 = 18'(in_data.wheel_three_speed);
	assign w4 = 18'(in_data.wheel_four_speed);

	mecodo_cordic #(
		.ANGLE_BITS  (ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor.start),
		.angle  (pose_heading_q),
		.done   (cor.done),
		.cos_val(cor_c),
		.sin_val(cor_s)
	);

	// multiplier operand selection by sequencer step
	always_comb begin
		case (state_q)
			S_M1:  begin mul_a = MA_W'(c_q); mul_b = MB_W'(sum_q); end
			S_M2:  begin mul_a = MA_W'(s_q); mul_b = MB_W'(lat_q); end
			S_M3:  begin mul_a = MA_W'(s_q); mul_b = MB_W'(sum_q); end
			S_M4:  begin mul_a = MA_W'(c_q); mul_b = MB_W'(lat_q); end
			S_M5:  begin mul_a = MA_W'(rx_q); mul_b = MB_W'({1'b0, radius_q}); end
			S_M6:  begin mul_a = MA_W'(ry_q); mul_b = MB_W'({1'b0, radius_q}); end
			S_M7:  begin mul_a = MA_W'(vx_q); mul_b = MB_W'({1'b0, dt_q}); end
			S_M8:  begin mul_a = MA_W'(vy_q); mul_b = MB_W'({1'b0, dt_q}); end
			S_M9:  begin mul_a = MA_W'(yaw_q); mul_b = MB_W'({1'b0, radius_q}); end
			S_M10: begin mul_a = MA_W'(prod_q); mul_b = MB_W'({1'b0, inv_axle_q}); end
			S_M11: begin
				mul_a = MA_W'((prod_q + (68'sd1 <<< 9)) >>> 10);
				mul_b = MB_W'({1'b0, dt_q});
			end
			S_M12: begin
				mul_a = MA_W'((prod_q + (68'sd1 <<< 15)) >>> 16);
				mul_b = INV_TWO_PI;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// rounding, pose sums and heading step
	always_comb begin
		diff = acc_q - prod_q;
		ssum = acc_q + prod_q;
		inc  = (prod_q + (68'sd1 <<< 25)) >>> 26;
		px_next = ACC_W'(pose_x_q) + ACC_W'(inc);
		py_next = ACC_W'(pose_y_q) + ACC_W'(inc);
		dh = ANGLE_BITS'((prod_q + (68'sd1 <<< (47 - ANGLE_BITS))) >>> (48 - ANGLE_BITS));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= WHEEL_RADIUS_RST;
			inv_axle_q <= INVERSE_AXLE_SUM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WHEEL_RADIUS:     radius_q   <= cfg_data;
				REG_INVERSE_AXLE_SUM: inv_axle_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pose_x_q       <= '0;
			pose_y_q       <= '0;
			pose_heading_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			prod_q <= mul_a * mul_b;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sum_q   <= w1 + w2 + w3 + w4;
						lat_q   <= -w1 + w2 + w3 - w4;
						yaw_q   <= -w1 + w2 - w3 + w4;
						dt_q    <= in_data.elapsed_time;
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cor.done) begin
						c_q     <= cor_c;
						s_q     <= cor_s;
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					acc_q   <= prod_q;
					state_q <= S_M3;
				end
				S_M3: begin
					rx_q    <= 22'((diff + (68'sd1 <<< 29)) >>> 30);
					state_q <= S_M4;
				end
				S_M4: begin
					acc_q   <= prod_q;
					state_q <= S_M5;
				end
				S_M5: begin
					ry_q    <= 22'((ssum + (68'sd1 <<< 29)) >>> 30);
					state_q <= S_M6;
				end
				S_M6: begin
					vx_q    <= 40'(prod_q);
					state_q <= S_M7;
				end
				S_M7: begin
					vy_q    <= 40'(prod_q);
					state_q <= S_M8;
				end
				S_M8: begin
					if (px_next > POS_HI) pose_x_q <= POSITION_BITS'(POS_HI);
					else if (px_next < POS_LO) pose_x_q <= POSITION_BITS'(POS_LO);
					else pose_x_q <= POSITION_BITS'(px_next);
					state_q <= S_M9;
				end
				S_M9: begin
					if (py_next > POS_HI) pose_y_q <= POSITION_BITS'(POS_HI);
					else if (py_next < POS_LO) pose_y_q <= POSITION_BITS'(POS_LO);
					else pose_y_q <= POSITION_BITS'(py_next);
					state_q <= S_M10;
				end
				S_M10: state_q <= S_M11;
				S_M11: begin
					om_q    <= 52'(prod_q);
					state_q <= S_M12;
				end
				S_M12: state_q <= S_M13;
				S_M13: begin
					pose_heading_q <= pose_heading_q + dh;
					state_q        <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.velocity_x <= sat16((PR_W'(vx_q) + (68'sd1 <<< 17)) >>> 18);
						out_q.velocity_y <= sat16((PR_W'(vy_q) + (68'sd1 <<< 17)) >>> 18);
						out_q.yaw_rate   <= sat16((PR_W'(om_q) + (68'sd1 <<< 25)) >>> 26);
						out_q.position_x <= sat32(ACC_W'(pose_x_q));
						out_q.position_y <= sat32(ACC_W'(pose_y_q));
						out_q.heading    <= 16'(pose_heading_q);
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer checks
	`MOI_ASSERT_SAME(a_busy_stalls, (state_q != S_IDLE), in_stall)
	`MOI_ASSERT_SAME(a_cordic_done_in_wait, cor.done, (state_q == S_CORDIC))
	`MOI_ASSERT_NEXT(a_heading_held_idle, (state_q == S_IDLE), $stable(pose_heading_q))
	`MOI_ASSERT_NEXT(a_accept_starts_cordic, in_acc, (state_q == S_CORDIC))

endmodule

`default_nettype wire
